[src/sla_pkg.sv]
// Shared constants for the serial line assembler.
package sla_pkg;

	localparam int LINE_BYTES = 64;
	localparam int LEN_W      = $clog2(LINE_BYTES);
	localparam int BYTE_W     = 8;
	localparam int CFG_W      = 7;

	localparam logic [LEN_W-1:0]  LEN_MAX       = LEN_W'(LINE_BYTES - 1);
	localparam logic [CFG_W-1:0]  MAX_LEN_RESET = 7'd64;
	localparam logic [BYTE_W-1:0] CH_CR         = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LF         = 8'd10;

endpackage

[src/serial_line_assembler_unit.sv]
// Serial line assembler: byte stream in, terminated line characters out.
// An ordinary byte is appended to the line store; a terminator on an empty line is dropped.
// A terminated line is walked out character by character, each read from the store (ST_RD)
// and then loaded into the output register (ST_LD), or gives one marker for an empty cut.
// Results sit in an output register, so the next byte is taken while one waits.
// Reset clears the line length, the sequencer and max_out_len (to 64); store contents persist.
module serial_line_assembler_unit import sla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_char
	output logic              m_tuser,   // [0] char_valid
	output logic              m_tlast,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data   // max_out_len
);

	logic [CFG_W-1:0]  max_len_q;
	logic              ram_wr_en;
	logic [LEN_W-1:0]  ram_wr_addr;
	logic [BYTE_W-1:0] ram_wr_data;
	logic              ram_rd_en;
	logic [LEN_W-1:0]  ram_rd_addr;
	logic [BYTE_W-1:0] ram_rd_data;

	// hold the output buffer size
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	sla_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_len     (max_len_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	sla_ram #(
		.Width (BYTE_W),
		.Depth (LINE_BYTES)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

[src/sla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sla_ram #(
	parameter int Width = 8,
	parameter int Depth = 64,
	localparam int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [Width-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);

	logic [Width-1:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/sla_ctrl.sv]
// Line sequencer: appends bytes to the store and walks it out on a terminator.
module sla_ctrl import sla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  max_len,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tuser,
	output logic              m_tlast,
	output logic              ram_wr_en,
	output logic [LEN_W-1:0]  ram_wr_addr,
	output logic [BYTE_W-1:0] ram_wr_data,
	output logic              ram_rd_en,
	output logic [LEN_W-1:0]  ram_rd_addr,
	input  logic [BYTE_W-1:0] ram_rd_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_LD,
		ST_EMPTY
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    idx_q;
	logic [LEN_W-1:0]    last_q;
	logic                m_tvalid_q;
	logic [BYTE_W-1:0]   m_tdata_q;
	logic                m_tuser_q;
	logic                m_tlast_q;

	logic                accept;
	logic                is_term;
	logic                slot_free;
	logic                load_c;
	logic [CFG_W-1:0]    cap_c;
	logic [LEN_W-1:0]    n_c;

	// decode the incoming request
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_term   = (s_tdata == CH_CR) || (s_tdata == CH_LF);
	assign slot_free = !m_tvalid_q || m_tready;
	assign load_c    = slot_free && ((state_q == ST_LD) || (state_q == ST_EMPTY));

	// clip the line length to one less than the output buffer size
	assign cap_c = (max_len == '0) ? '0 : max_len - 7'd1;
	assign n_c   = ({1'b0, len_q} < cap_c) ? len_q : cap_c[LEN_W-1:0];

	// store port: append on write, walk on read
	assign ram_wr_en   = accept && !is_term && (len_q < LEN_MAX);
	assign ram_wr_addr = len_q;
	assign ram_wr_data = s_tdata;
	assign ram_rd_en   = (state_q == ST_RD);
	assign ram_rd_addr = idx_q;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			idx_q      <= '0;
			last_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			// hold the result until taken, load a new one when the slot frees
			m_tvalid_q <= load_c || (m_tvalid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!is_term) begin
							// append, or resync on an overlong line
							len_q <= (len_q < LEN_MAX) ? len_q + 1'b1 : '0;
						end else if (len_q != '0) begin
							len_q <= '0;
							idx_q <= '0;
							if (n_c == '0) begin
								state_q <= ST_EMPTY;
							end else begin
								last_q  <= n_c - 1'b1;
								state_q <= ST_RD;
							end
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					// hand the character to the output when the slot frees
					if (slot_free) begin
						m_tdata_q  <= ram_rd_data;
						m_tuser_q  <= 1'b1;
						m_tlast_q  <= (idx_q == last_q);
						if (idx_q == last_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_EMPTY: begin
					// emit the empty-cut marker
					if (slot_free) begin
						m_tdata_q  <= '0;
						m_tuser_q  <= 1'b0;
						m_tlast_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
